// ===== rtl/mhpq_pkg.sv =====
// shared types and codes for the max-heap priority queue
package mhpq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
        logic        [4:0]  position;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] result_value;
        logic        [5:0]  prior_count;
    } rsp_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/max_heap_priority_queue_core.sv =====
// top level of the bounded binary max-heap priority queue
//
// A request is taken at a clock edge where start is high and busy is low.
// An insert puts request.value into the heap and reports the count held
// before it; a delete removes the entry at request.position (position 0 is
// the maximum) and returns it. Full, empty and out-of-range requests change
// nothing and give their status in the cycle after start. Every request gives
// exactly one result, shown on the result port for a single cycle with done
// high; the receiver cannot stall it, so it must take it in that cycle.
// The heap sits in a ram with one read and one write port and a
// registered read, and a single signed comparator serves every step. An
// insert climbs from the next free slot, reading and comparing the parent
// at each level and moving a smaller parent down into the hole, and writes
// the value at the root or below a parent that is not smaller. A delete
// fetches the removed entry and, unless that was the last slot, the last
// entry, tests the parent when the slot is not the root, then climbs as an
// insert does or sinks past the larger child at each level to place it.
// busy is high for the whole operation, and a new request may start in the
// cycle that its predecessor's result is shown.
module max_heap_priority_queue_core #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mhpq_pkg::req_t request,
    output logic          done,
    output mhpq_pkg::rsp_t result
);

    import mhpq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHD_W = IDX_W + 2;
    localparam int POS_W = CNT_W + 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_DEL_RES,
        S_DEL_LAST,
        S_DEL_UP,
        S_DN_CHECK,
        S_DN_L,
        S_DN_R
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] cur_reg, cur_next;
    logic signed [31:0] best_reg, best_next;
    logic               best_hit_reg, best_hit_next;
    rsp_t               result_reg, result_next;
    logic               done_reg, done_next;

    // ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] rd_val;

    // the one shared comparator
    logic signed [31:0] cmp_a, cmp_b;
    logic               cmp_gt;

    // index arithmetic
    logic [IDX_W-1:0]   idx_m1;
    logic [IDX_W-1:0]   parent_idx;
    logic [CHD_W-1:0]   left_w, right_w, count_cw;
    logic [POS_W-1:0]   pos_w, count_pw;
    logic [CNT_W+5:0]   count_wide;
    logic [5:0]         prior6;

    mhpq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val = $signed(ram_rdata);
    assign cmp_gt = cmp_a > cmp_b;

    assign idx_m1     = idx_reg - IDX_W'(1);
    assign parent_idx = idx_m1 >> 1;
    assign left_w     = {1'b0, idx_reg, 1'b1};
    assign right_w    = left_w + CHD_W'(1);
    assign count_cw   = CHD_W'(count_reg);
    assign pos_w      = POS_W'(request.position);
    assign count_pw   = POS_W'(count_reg);
    // prior count wraps modulo 64 for deep heaps
    assign count_wide = {6'd0, count_reg};
    assign prior6     = count_wide[5:0];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        best_hit_next = best_hit_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = cur_reg;
        ram_re        = 1'b0;
        ram_raddr     = parent_idx;
        cmp_a         = cur_reg;
        cmp_b         = rd_val;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.prior_count  = prior6;
                    result_next.result_value = '0;
                    result_next.status       = STATUS_OK;
                    if (request.op == OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            result_next.status = STATUS_FULL;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            // hole starts at the next free slot
                            cur_next   = request.value;
                            idx_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_UP_CHECK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        result_next.status = STATUS_EMPTY;
                        done_next          = 1'b1;
                    end
                    else if (pos_w >= count_pw)
                    begin
                        result_next.status = STATUS_RANGE;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = pos_w[IDX_W-1:0];
                        idx_next   = pos_w[IDX_W-1:0];
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DEL_RES;
                    end
                end
            end

            S_UP_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    // parent moves down into the hole
                    ram_wdata  = ram_rdata;
                    idx_next   = parent_idx;
                    state_next = S_UP_CHECK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DEL_RES:
            begin
                result_next.result_value = rd_val;
                if (CNT_W'(idx_reg) == count_reg)
                begin
                    // last slot removed, nothing to restore
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = count_reg[IDX_W-1:0];
                    state_next = S_DEL_LAST;
                end
            end

            S_DEL_LAST:
            begin
                cur_next = rd_val;
                if (idx_reg != '0)
                begin
                    ram_re     = 1'b1;
                    state_next = S_DEL_UP;
                end
                else
                begin
                    state_next = S_DN_CHECK;
                end
            end

            S_DEL_UP:
            begin
                if (cmp_gt)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = parent_idx;
                    state_next = S_UP_CHECK;
                end
                else
                begin
                    state_next = S_DN_CHECK;
                end
            end

            S_DN_CHECK:
            begin
                if (left_w < count_cw)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_w[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DN_L:
            begin
                cmp_a = rd_val;
                cmp_b = cur_reg;
                if (right_w < count_cw)
                begin
                    best_hit_next = cmp_gt;
                    best_next     = cmp_gt ? rd_val : cur_reg;
                    ram_re        = 1'b1;
                    ram_raddr     = right_w[IDX_W-1:0];
                    state_next    = S_DN_R;
                end
                else if (cmp_gt)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = left_w[IDX_W-1:0];
                    state_next = S_DN_CHECK;
                end
                else
                begin
                    ram_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DN_R:
            begin
                cmp_a  = rd_val;
                cmp_b  = best_reg;
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata  = ram_rdata;
                    idx_next   = right_w[IDX_W-1:0];
                    state_next = S_DN_CHECK;
                end
                else if (best_hit_reg)
                begin
                    ram_wdata  = best_reg;
                    idx_next   = left_w[IDX_W-1:0];
                    state_next = S_DN_CHECK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            cur_reg      <= '0;
            best_reg     <= '0;
            best_hit_reg <= 1'b0;
            result_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            cur_reg      <= cur_next;
            best_reg     <= best_next;
            best_hit_reg <= best_hit_next;
            result_reg   <= result_next;
            done_reg     <= done_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sim/heap_order_checker.sv =====
// checker for the max-heap priority queue: predicts every request and compares its result
`timescale 1ns / 1ps

module heap_order_checker #(
    parameter int CAPACITY = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  mhpq_pkg::req_t request,
    input  logic           done,
    input  mhpq_pkg::rsp_t result,
    output int             fail_count,
    output int             pending,
    output int             held
);

    import mhpq_pkg::*;

    logic signed [31:0] heap_slots [CAPACITY];
    int                 entry_count;
    rsp_t               due_results [$];

    function automatic void swap_slots(input int a, input int b);
        logic signed [31:0] t;
        t             = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = t;
    endfunction

    // no swap on equal values
    function automatic void sift_up(input int i);
        int   p;
        logic climbing;
        climbing = 1'b1;
        while (climbing && i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_slots[i] > heap_slots[p])
            begin
                swap_slots(i, p);
                i = p;
            end
            else
            begin
                climbing = 1'b0;
            end
        end
    endfunction

    function automatic void sift_down(input int i);
        int   l;
        int   r;
        int   m;
        logic sinking;
        sinking = 1'b1;
        while (sinking)
        begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < entry_count && heap_slots[l] > heap_slots[m])
                m = l;
            if (r < entry_count && heap_slots[r] > heap_slots[m])
                m = r;
            if (m == i)
            begin
                sinking = 1'b0;
            end
            else
            begin
                swap_slots(i, m);
                i = m;
            end
        end
    endfunction

    function automatic rsp_t apply_heap_op(input req_t r);
        rsp_t o;
        int   p;
        int   last;
        o.status       = STATUS_OK;
        o.result_value = '0;
        o.prior_count  = 6'(entry_count);
        if (r.op == OP_INSERT)
        begin
            if (entry_count >= CAPACITY)
            begin
                o.status = STATUS_FULL;
            end
            else
            begin
                heap_slots[entry_count] = r.value;
                entry_count++;
                sift_up(entry_count - 1);
            end
        end
        else if (entry_count == 0)
        begin
            o.status = STATUS_EMPTY;
        end
        else if (int'(r.position) >= entry_count)
        begin
            o.status = STATUS_RANGE;
        end
        else
        begin
            p              = int'(r.position);
            last           = entry_count - 1;
            o.result_value = heap_slots[p];
            heap_slots[p]  = heap_slots[last];
            entry_count    = last;
            // the last slot itself is just dropped
            if (p < entry_count)
            begin
                if (p > 0 && heap_slots[p] > heap_slots[(p - 1) / 2])
                    sift_up(p);
                else
                    sift_down(p);
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            due_results.delete();
            entry_count = 0;
            fail_count  = 0;
        end
        else
        begin
            // accept first, so a zero-wait result still finds its request
            if (start && !busy)
                due_results.push_back(apply_heap_op(request));
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        fail_count++;
                    end
                    if (result.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, result.result_value);
                        fail_count++;
                    end
                    if (result.prior_count !== want.prior_count)
                    begin
                        $error("prior_count: expected %0d, got %0d",
                               want.prior_count, result.prior_count);
                        fail_count++;
                    end
                end
            end
        end
        pending = due_results.size();
        held    = entry_count;
    end

endmodule

// ===== sim/tb_max_heap_priority_queue_core.sv =====
// testbench top for the max-heap priority queue: stimulus, timeout and verdict
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_core;

    import mhpq_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_COUNT = 1150;
    // covers the slowest request plus sender gaps for every request; this is
    // several times the slowest correct run
    localparam int CYCLE_LIMIT  = 400000;
    // outlasts the longest operation
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } burst_mode_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    int          fail_count;
    int          pending;
    int          held;
    int          idle_pct;
    int unsigned cycle_count;

    // free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    max_heap_priority_queue_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // watches both channels, predicts and counts mismatches
    heap_order_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending),
        .held       (held)
    );

    // hard stop in case the block hangs
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly random patterns, with the extremes and a narrow band so that
    // equal values show up in the heap often
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2, 3:    v = $urandom_range(15) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // most deletes name a slot that is held; the rest roam the whole range
    function automatic logic [4:0] pick_position();
        logic [4:0] p;
        if (held > 0 && $urandom_range(99) < 80)
            p = 5'($urandom_range(held - 1));
        else
            p = 5'($urandom_range(31));
        return p;
    endfunction

    // drive one request from a falling edge and hold it until the block
    // takes it; idle cycles before it carry random junk with start low
    task automatic issue(input logic op_i, input logic signed [31:0] v, input logic [4:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            start            <= 1'b0;
            request.op       <= 1'($urandom);
            request.value    <= $urandom;
            request.position <= 5'($urandom);
            @(negedge clk);
        end
        start            <= 1'b1;
        request.op       <= op_i;
        request.value    <= v;
        request.position <= p;
        // taken at the rising edge where busy is low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int          phase_idle [4];
        int          sent;
        int          burst_len;
        int          insert_pct;
        burst_mode_t mode;

        phase_idle = '{0, 71, 27, 0};
        start      = 1'b0;
        request    = '0;
        rst_n      = 1'b0;
        idle_pct   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty heap, extremes, equal values, out-of-range slots,
        // last-slot delete, middle delete, dequeue down to empty again
        issue(OP_DELETE, 32'sd0, 5'd0);
        issue(OP_DELETE, 32'sd0, 5'd31);
        issue(OP_INSERT, 32'sd0, 5'd0);
        issue(OP_INSERT, 32'sh7fff_ffff, 5'd31);
        issue(OP_INSERT, 32'sh8000_0000, 5'd0);
        issue(OP_INSERT, -32'sd1, 5'd0);
        issue(OP_INSERT, 32'sd5, 5'd0);
        issue(OP_INSERT, 32'sd5, 5'd0);
        issue(OP_DELETE, 32'sd0, 5'd6);
        issue(OP_DELETE, 32'sh7fff_ffff, 5'd31);
        issue(OP_DELETE, 32'sd0, 5'd5);
        issue(OP_DELETE, 32'sd0, 5'd1);
        issue(OP_DELETE, 32'sd0, 5'd0);
        issue(OP_INSERT, 32'sd1, 5'd0);
        issue(OP_INSERT, 32'sd1, 5'd0);
        issue(OP_DELETE, 32'sd0, 5'd2);
        repeat (4) issue(OP_DELETE, 32'sd0, 5'd0);
        issue(OP_DELETE, 32'sd0, 5'd0);

        // random: four sender phases, each cut into bursts that push the heap
        // toward full, drain it toward empty, or churn around the middle
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            while (sent < (ph + 1) * RANDOM_COUNT / 4)
            begin
                mode      = burst_mode_t'($urandom_range(2));
                burst_len = $urandom_range(60, 30);
                // some bursts run with no gaps at all
                idle_pct  = ($urandom_range(4) == 0) ? 0 : phase_idle[ph];
                case (mode)
                    MODE_FILL:  insert_pct = 90;
                    MODE_DRAIN: insert_pct = 15;
                    default:    insert_pct = 50;
                endcase
                for (int k = 0; k < burst_len; k++)
                begin
                    if ($urandom_range(99) < insert_pct)
                        issue(OP_INSERT, pick_value(), 5'($urandom));
                    else
                        issue(OP_DELETE, $urandom, pick_position());
                    sent++;
                end
            end
        end
        start <= 1'b0;

        // wait for every outstanding result, then watch for strays
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
